// ----- src/psgwd_pkg.sv -----
package psgwd_pkg;

  localparam int NUM_CHIPS_DEF = 2;

  localparam int BYTE_W = 8;
  localparam int CHAN_W = 3;
  localparam int FREQ_W = 16;
  localparam int VOL_W  = 6;
  localparam int DIV_W  = 11;
  localparam int DIV_STEPS = 18;
  localparam int STEP_W = 5;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  localparam logic [3:0] HI_LATCH0 = 4'h8;
  localparam logic [3:0] HI_LATCH1 = 4'hA;
  localparam logic [3:0] HI_LATCH2 = 4'hC;
  localparam logic [3:0] HI_NOISE  = 4'hE;

  localparam logic [1:0] NOISE_TONE2 = 2'd3;
  localparam logic [1:0] CH_TONE2    = 2'd2;
  localparam logic [1:0] CH_NOISE    = 2'd3;

  localparam logic [FREQ_W-1:0] FREQ_NOISE0 = 16'd20000;
  localparam logic [FREQ_W-1:0] FREQ_NOISE1 = 16'd10000;
  localparam logic [FREQ_W-1:0] FREQ_NOISE2 = 16'd5000;

  localparam logic KIND_FREQ = 1'b0;
  localparam logic KIND_VOL  = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic              kind;
    logic [FREQ_W-1:0] freq;
    logic [VOL_W-1:0]  vol;
    logic              last;
  } result_t;

endpackage

// ----- src/psg_write_decoder.sv -----
// Latch bytes, ignored bytes and bytes for an absent chip: taken with no word out.
// Noise and volume bytes: result word valid in the cycle after the byte is taken.
// Tone data bytes: serial restoring divider (ST_DIV), then ST_FIN, then the word is valid in ST_EMIT.
// Not ready again until every result word of the byte has been taken.
// rst_n (synchronous, active low) clears the tone latch, noise modes and tone 2 frequencies.
module psg_write_decoder #(
  parameter int NUM_CHIPS = psgwd_pkg::NUM_CHIPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [psgwd_pkg::IN_TDATA_W-1:0]   in_tdata,   // write_byte[7:0]
  input  logic                               in_tuser,   // chip_select[0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // channel[2:0], frequency_hz[18:3], volume_level[24:19], zero[31:25]
  output logic [psgwd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                               out_tuser,  // update_kind[0]
  output logic                               out_tlast
);
  import psgwd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [BYTE_W-1:0] latch_r, latch_nxt;
  logic [1:0]        noise_mode_r [NUM_CHIPS];
  logic [1:0]        noise_mode_nxt [NUM_CHIPS];
  logic [FREQ_W-1:0] t2f_r [NUM_CHIPS];
  logic [FREQ_W-1:0] t2f_nxt [NUM_CHIPS];
  logic              chip_r, chip_nxt;
  logic [1:0]        ch_r, ch_nxt;
  logic [DIV_W-1:0]  d_r, d_nxt;
  logic              d_small_r, d_small_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [FREQ_W-1:0] quo_r, quo_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  result_t           res_r, res_nxt;

  logic              accept;
  logic [BYTE_W-1:0] wbyte;
  logic [3:0]        hi;
  logic              chip_ok;
  logic              sel_chip;
  logic [1:0]        nm_sel;
  logic [FREQ_W-1:0] t2f_sel;
  logic [DIV_W:0]    trial;
  logic              ge;
  logic [FREQ_W-1:0] f_fin;
  logic [FREQ_W-1:0] noise_f;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign wbyte     = in_tdata;
  assign hi        = wbyte[7:4];
  assign chip_ok   = ({1'b0, in_tuser} < 2'(NUM_CHIPS));
  assign sel_chip  = (state_r == ST_IDLE) ? in_tuser : chip_r;

  always_comb begin
    nm_sel  = '0;
    t2f_sel = '0;
    for (int i = 0; i < NUM_CHIPS; i++) begin
      if ({1'b0, sel_chip} == 2'(i)) begin
        nm_sel  = noise_mode_r[i];
        t2f_sel = t2f_r[i];
      end
    end
  end

  always_comb begin
    case (wbyte[1:0])
      2'd0:    noise_f = FREQ_NOISE0;
      2'd1:    noise_f = FREQ_NOISE1;
      2'd2:    noise_f = FREQ_NOISE2;
      default: noise_f = t2f_sel;
    endcase
  end

  assign trial = {rem_r, (cnt_r == '0)};
  assign ge    = (trial >= {1'b0, d_r});
  assign f_fin = d_small_r ? '0 : quo_r;

  always_comb begin
    state_nxt   = state_r;
    latch_nxt   = latch_r;
    chip_nxt    = chip_r;
    ch_nxt      = ch_r;
    d_nxt       = d_r;
    d_small_nxt = d_small_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    cnt_nxt     = cnt_r;
    pend_nxt    = pend_r;
    res_nxt     = res_r;
    for (int i = 0; i < NUM_CHIPS; i++) begin
      noise_mode_nxt[i] = noise_mode_r[i];
      t2f_nxt[i]        = t2f_r[i];
    end

    case (state_r)
      ST_IDLE: begin
        if (accept && chip_ok) begin
          if (hi == HI_NOISE) begin
            for (int i = 0; i < NUM_CHIPS; i++) begin
              if ({1'b0, in_tuser} == 2'(i)) noise_mode_nxt[i] = wbyte[1:0];
            end
            res_nxt   = '{channel: {in_tuser, CH_NOISE}, kind: KIND_FREQ, freq: noise_f,
                          vol: '0, last: 1'b1};
            pend_nxt  = 1'b0;
            state_nxt = ST_EMIT;
          end else if (hi == HI_LATCH0 || hi == HI_LATCH1 || hi == HI_LATCH2) begin
            latch_nxt = wbyte;
          end else if (wbyte[7]) begin
            res_nxt   = '{channel: {in_tuser, wbyte[6:5]}, kind: KIND_VOL, freq: '0,
                          vol: {~wbyte[3:0], 2'b00}, last: 1'b1};
            pend_nxt  = 1'b0;
            state_nxt = ST_EMIT;
          end else if (latch_r[7:6] != 2'b00) begin
            chip_nxt    = in_tuser;
            ch_nxt      = latch_r[6:5];
            d_nxt       = {1'b0, wbyte[5:0], latch_r[3:0]} + DIV_W'(1);
            d_small_nxt = (wbyte[5:0] == '0) && (latch_r[3:1] == '0);
            rem_nxt     = '0;
            quo_nxt     = '0;
            cnt_nxt     = '0;
            state_nxt   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? DIV_W'(trial - {1'b0, d_r}) : trial[DIV_W-1:0];
        quo_nxt = {quo_r[FREQ_W-2:0], ge};
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        pend_nxt = 1'b0;
        res_nxt  = '{channel: {chip_r, ch_r}, kind: KIND_FREQ, freq: f_fin,
                     vol: '0, last: 1'b1};
        if (ch_r == CH_TONE2) begin
          for (int i = 0; i < NUM_CHIPS; i++) begin
            if ({1'b0, chip_r} == 2'(i)) t2f_nxt[i] = f_fin;
          end
          if (nm_sel == NOISE_TONE2) begin
            res_nxt.channel = {chip_r, CH_NOISE};
            res_nxt.last    = 1'b0;
            pend_nxt        = 1'b1;
          end
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_tready) begin
          if (pend_r) begin
            res_nxt.channel = {chip_r, CH_TONE2};
            res_nxt.last    = 1'b1;
            pend_nxt        = 1'b0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      latch_r <= '0;
      pend_r  <= 1'b0;
      for (int i = 0; i < NUM_CHIPS; i++) begin
        noise_mode_r[i] <= '0;
        t2f_r[i]        <= '0;
      end
    end else begin
      state_r <= state_nxt;
      latch_r <= latch_nxt;
      pend_r  <= pend_nxt;
      for (int i = 0; i < NUM_CHIPS; i++) begin
        noise_mode_r[i] <= noise_mode_nxt[i];
        t2f_r[i]        <= t2f_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    chip_r    <= chip_nxt;
    ch_r      <= ch_nxt;
    d_r       <= d_nxt;
    d_small_r <= d_small_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
    res_r     <= res_nxt;
  end

  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tdata  = {7'b0, res_r.vol, res_r.freq, res_r.channel};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result word is pending");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("tone 2 word missing after noise word");

  a_pair_is_noise: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[1:0] == CH_NOISE && out_tuser == KIND_FREQ)
    else $error("first of two words is not a noise frequency");

  a_vol_no_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_VOL |-> out_tdata[18:3] == '0)
    else $error("volume word carries a frequency");

endmodule
